FILE: hdl/mrt_pkg.sv
// mrt_pkg: shared types and constants for the memory region table.
// Holds the table geometry, operation and status codes, the entry record
// and the sequencer state type. No dependencies.
`timescale 1ns / 1ps

package mrt_pkg;

  localparam int MAX_REGIONS = 64;
  localparam int IDX_W       = 6;   // bits to address one entry
  localparam int CNT_W       = 7;   // bits to hold 0..MAX_REGIONS
  localparam int ADDR_W      = 64;

  localparam int S_TDATA_W = 264;
  localparam int M_TDATA_W = 144;

  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0,
    OP_ADD   = 3'd1,
    OP_FIND  = 3'd2,
    OP_FIT   = 3'd3,
    OP_MERGE = 3'd4,
    OP_SPLIT = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_BADSPLIT = 2'd3
  } status_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] len;
    logic              free;
  } region_t;

  typedef struct packed {
    logic                we;
    logic [IDX_W-1:0]    waddr;
    region_t             wdata;
    logic [IDX_W-1:0]    raddr;
  } mem_ctl_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ADD,
    S_FIND_RD,
    S_FIND_CMP,
    S_FIT_RD,
    S_FIT_CMP,
    S_SORT_KEY_RD,
    S_SORT_KEY,
    S_SORT_CMP,
    S_SORT_PUT,
    S_MRG_START,
    S_MRG_FIRST,
    S_MRG_CMP,
    S_MRG_LAST,
    S_SPL_RD,
    S_SPL_CHK,
    S_SPL_SHIFT_RD,
    S_SPL_SHIFT_WR,
    S_SPL_NEW,
    S_SPL_CUT,
    S_DONE
  } state_t;

endpackage

FILE: hdl/memory_region_table.sv
// memory_region_table: region table with add, find, best fit, merge, split.
// One sequencer drives a single-port-write, single-port-read entry RAM.
// Depends on mrt_pkg.
`timescale 1ns / 1ps

// Usage
//   Input channel s_*: one transaction per operation. s_tuser carries the
//   operation code, s_tdata the operands. s_tready is high only while the
//   sequencer is idle; each operation is worked entry by entry through the
//   one RAM read port and one write port.
//   Output channel m_*: one transaction per operation with status, the hit
//   entry and the entry count. The result sits in an output register, so a
//   new operation is accepted while it waits; the sequencer only holds in
//   its final step if the previous result is still not taken.
//   Operations (n = entries): find is a binary search, best fit a scan of
//   all n entries, split moves each entry above the split one place up,
//   merge is an insertion sort by base followed by one join pass and the
//   output step. The registered RAM read gives each read-compare loop a
//   read step and a compare step.
//   Reset clears the entry count and the output valid; the RAM contents
//   are not cleared and need no clearing pass.

module memory_region_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [63:0] base, [127:64] length, [128] free_flag, [192:129] request_size,
  // [198:193] entry_index, [262:199] split_offset, [263] zero
  input  logic [mrt_pkg::S_TDATA_W-1:0] s_tdata,
  // [2:0] op
  input  logic [2:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [1:0] status, [7:2] hit_index, [71:8] hit_base, [135:72] hit_length,
  // [136] hit_free, [143:137] entries_now
  output logic [mrt_pkg::M_TDATA_W-1:0] m_tdata
);

  localparam int IW = mrt_pkg::IDX_W;
  localparam int CW = mrt_pkg::CNT_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(mrt_pkg::MAX_REGIONS);

  mrt_pkg::state_t  state, state_next;
  mrt_pkg::mem_ctl_t mc;
  mrt_pkg::region_t mem [mrt_pkg::MAX_REGIONS];
  mrt_pkg::region_t rdata;

  // latched operands
  logic [63:0]   base_q, len_q, req_q, off_q;
  logic          free_q;
  logic [IW-1:0] eidx;

  logic [CW-1:0] count;
  logic [CW-1:0] idx_i, idx_j, out_idx;
  logic [CW-1:0] lo, hi, mid;
  mrt_pkg::region_t key, cur;

  // result being built
  logic [1:0]    res_status;
  logic [IW-1:0] res_idx;
  logic [63:0]   res_base, res_len;
  logic          res_free;
  logic          have;

  logic          accept;
  logic [1:0]    init_status;
  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid_c;
  logic [CW-1:0] eidx_p1;
  logic          fit_cand;
  logic          mrg_join;
  logic          sort_gt;

  assign accept   = s_tvalid && s_tready;
  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid_c    = mid_sum[CW:1];
  assign eidx_p1  = {1'b0, eidx} + CW'(1);
  assign fit_cand = rdata.free && (rdata.len >= req_q) && (!have || rdata.len < res_len);
  assign mrg_join = ((cur.base + cur.len) == rdata.base) && (cur.free == rdata.free);
  assign sort_gt  = rdata.base > key.base;

  // status already known when the operation is taken
  always_comb begin
    init_status = mrt_pkg::ST_OK;
    case (s_tuser)
      mrt_pkg::OP_ADD:   if (count >= MAX_CNT) init_status = mrt_pkg::ST_FULL;
      mrt_pkg::OP_FIND:  if (count == '0) init_status = mrt_pkg::ST_NOTFOUND;
      mrt_pkg::OP_FIT:   if (count == '0) init_status = mrt_pkg::ST_NOTFOUND;
      mrt_pkg::OP_SPLIT: begin
        if ({1'b0, s_tdata[198:193]} >= count) init_status = mrt_pkg::ST_BADSPLIT;
      end
      default: ;
    endcase
  end

  // entry RAM
  always_ff @(posedge clk) begin
    if (mc.we) begin
      mem[mc.waddr] <= mc.wdata;
    end
    rdata <= mem[mc.raddr];
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mrt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mrt_pkg::S_IDLE: begin
        if (accept) begin
          case (s_tuser)
            mrt_pkg::OP_ADD:   state_next = (count >= MAX_CNT) ? mrt_pkg::S_DONE
                                                               : mrt_pkg::S_ADD;
            mrt_pkg::OP_FIND:  state_next = (count == '0) ? mrt_pkg::S_DONE
                                                          : mrt_pkg::S_FIND_RD;
            mrt_pkg::OP_FIT:   state_next = (count == '0) ? mrt_pkg::S_DONE
                                                          : mrt_pkg::S_FIT_RD;
            mrt_pkg::OP_MERGE: state_next = (count > CW'(1)) ? mrt_pkg::S_SORT_KEY_RD
                                                             : mrt_pkg::S_DONE;
            mrt_pkg::OP_SPLIT: state_next = ({1'b0, s_tdata[198:193]} >= count)
                                            ? mrt_pkg::S_DONE : mrt_pkg::S_SPL_RD;
            default:           state_next = mrt_pkg::S_DONE;
          endcase
        end
      end
      mrt_pkg::S_ADD:      state_next = mrt_pkg::S_DONE;
      mrt_pkg::S_FIND_RD:  state_next = (lo > hi) ? mrt_pkg::S_DONE : mrt_pkg::S_FIND_CMP;
      mrt_pkg::S_FIND_CMP: begin
        if (rdata.base == base_q) begin
          state_next = mrt_pkg::S_DONE;
        end else if (rdata.base > base_q && mid == '0) begin
          state_next = mrt_pkg::S_DONE;
        end else begin
          state_next = mrt_pkg::S_FIND_RD;
        end
      end
      mrt_pkg::S_FIT_RD:   state_next = mrt_pkg::S_FIT_CMP;
      mrt_pkg::S_FIT_CMP:  state_next = (idx_i + CW'(1) < count) ? mrt_pkg::S_FIT_RD
                                                                 : mrt_pkg::S_DONE;
      mrt_pkg::S_SORT_KEY_RD: state_next = mrt_pkg::S_SORT_KEY;
      mrt_pkg::S_SORT_KEY:    state_next = mrt_pkg::S_SORT_CMP;
      mrt_pkg::S_SORT_CMP: begin
        if (sort_gt && idx_j > CW'(1)) begin
          state_next = mrt_pkg::S_SORT_CMP;
        end else begin
          state_next = mrt_pkg::S_SORT_PUT;
        end
      end
      mrt_pkg::S_SORT_PUT:  state_next = (idx_i + CW'(1) < count) ? mrt_pkg::S_SORT_KEY_RD
                                                                  : mrt_pkg::S_MRG_START;
      mrt_pkg::S_MRG_START: state_next = mrt_pkg::S_MRG_FIRST;
      mrt_pkg::S_MRG_FIRST: state_next = mrt_pkg::S_MRG_CMP;
      mrt_pkg::S_MRG_CMP:   state_next = (idx_i + CW'(1) < count) ? mrt_pkg::S_MRG_CMP
                                                                  : mrt_pkg::S_MRG_LAST;
      mrt_pkg::S_MRG_LAST:  state_next = mrt_pkg::S_DONE;
      mrt_pkg::S_SPL_RD:    state_next = mrt_pkg::S_SPL_CHK;
      mrt_pkg::S_SPL_CHK: begin
        if (off_q >= rdata.len || count >= MAX_CNT) begin
          state_next = mrt_pkg::S_DONE;
        end else if (count > eidx_p1) begin
          state_next = mrt_pkg::S_SPL_SHIFT_RD;
        end else begin
          state_next = mrt_pkg::S_SPL_NEW;
        end
      end
      mrt_pkg::S_SPL_SHIFT_RD: state_next = mrt_pkg::S_SPL_SHIFT_WR;
      mrt_pkg::S_SPL_SHIFT_WR: state_next = (idx_i - CW'(1) > eidx_p1)
                                            ? mrt_pkg::S_SPL_SHIFT_RD : mrt_pkg::S_SPL_NEW;
      mrt_pkg::S_SPL_NEW:  state_next = mrt_pkg::S_SPL_CUT;
      mrt_pkg::S_SPL_CUT:  state_next = mrt_pkg::S_DONE;
      mrt_pkg::S_DONE:     state_next = (!m_tvalid || m_tready) ? mrt_pkg::S_IDLE
                                                                : mrt_pkg::S_DONE;
      default:             state_next = mrt_pkg::S_IDLE;
    endcase
  end

  // RAM control and handshake outputs
  always_comb begin
    mc       = '0;
    s_tready = (state == mrt_pkg::S_IDLE);
    case (state)
      mrt_pkg::S_ADD: begin
        mc.we    = 1'b1;
        mc.waddr = count[IW-1:0];
        mc.wdata = '{base: base_q, len: len_q, free: free_q};
      end
      mrt_pkg::S_FIND_RD:     mc.raddr = mid_c[IW-1:0];
      mrt_pkg::S_FIT_RD:      mc.raddr = idx_i[IW-1:0];
      mrt_pkg::S_SORT_KEY_RD: mc.raddr = idx_i[IW-1:0];
      mrt_pkg::S_SORT_KEY: begin
        mc.raddr = IW'(idx_j - CW'(1));
      end
      mrt_pkg::S_SORT_CMP: begin
        mc.raddr = IW'(idx_j - CW'(2));
        if (sort_gt) begin
          mc.we    = 1'b1;
          mc.waddr = idx_j[IW-1:0];
          mc.wdata = rdata;
        end
      end
      mrt_pkg::S_SORT_PUT: begin
        mc.we    = 1'b1;
        mc.waddr = idx_j[IW-1:0];
        mc.wdata = key;
      end
      mrt_pkg::S_MRG_START: mc.raddr = '0;
      mrt_pkg::S_MRG_FIRST: mc.raddr = IW'(1);
      mrt_pkg::S_MRG_CMP: begin
        mc.raddr = IW'(idx_i + CW'(1));
        if (!mrg_join) begin
          mc.we    = 1'b1;
          mc.waddr = out_idx[IW-1:0];
          mc.wdata = cur;
        end
      end
      mrt_pkg::S_MRG_LAST: begin
        mc.we    = 1'b1;
        mc.waddr = out_idx[IW-1:0];
        mc.wdata = cur;
      end
      mrt_pkg::S_SPL_RD:       mc.raddr = eidx;
      mrt_pkg::S_SPL_SHIFT_RD: mc.raddr = IW'(idx_i - CW'(1));
      mrt_pkg::S_SPL_SHIFT_WR: begin
        mc.we    = 1'b1;
        mc.waddr = idx_i[IW-1:0];
        mc.wdata = rdata;
      end
      mrt_pkg::S_SPL_NEW: begin
        mc.we    = 1'b1;
        mc.waddr = eidx_p1[IW-1:0];
        mc.wdata = '{base: key.base + off_q, len: key.len - off_q, free: key.free};
      end
      mrt_pkg::S_SPL_CUT: begin
        mc.we    = 1'b1;
        mc.waddr = eidx;
        mc.wdata = '{base: key.base, len: off_q, free: key.free};
      end
      default: ;
    endcase
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (state)
        mrt_pkg::S_IDLE: begin
          if (accept && s_tuser == mrt_pkg::OP_CLEAR) begin
            count <= '0;
          end
        end
        mrt_pkg::S_ADD:      count <= count + CW'(1);
        mrt_pkg::S_MRG_LAST: count <= out_idx + CW'(1);
        mrt_pkg::S_SPL_CUT:  count <= count + CW'(1);
        default: ;
      endcase
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    case (state)
      mrt_pkg::S_IDLE: begin
        if (accept) begin
          base_q     <= s_tdata[63:0];
          len_q      <= s_tdata[127:64];
          free_q     <= s_tdata[128];
          req_q      <= s_tdata[192:129];
          eidx       <= s_tdata[198:193];
          off_q      <= s_tdata[262:199];
          res_status <= init_status;
          res_idx    <= '0;
          res_base   <= '0;
          res_len    <= '0;
          res_free   <= 1'b0;
          have       <= 1'b0;
          lo         <= '0;
          hi         <= count - CW'(1);
          idx_i      <= (s_tuser == mrt_pkg::OP_MERGE) ? CW'(1) : '0;
        end
      end
      mrt_pkg::S_ADD: begin
        res_idx  <= count[IW-1:0];
        res_base <= base_q;
        res_len  <= len_q;
        res_free <= free_q;
      end
      // binary search
      mrt_pkg::S_FIND_RD: begin
        mid <= mid_c;
        if (lo > hi) res_status <= mrt_pkg::ST_NOTFOUND;
      end
      mrt_pkg::S_FIND_CMP: begin
        if (rdata.base == base_q) begin
          res_idx  <= mid[IW-1:0];
          res_base <= rdata.base;
          res_len  <= rdata.len;
          res_free <= rdata.free;
        end else if (rdata.base < base_q) begin
          lo <= mid + CW'(1);
        end else if (mid == '0) begin
          res_status <= mrt_pkg::ST_NOTFOUND;
        end else begin
          hi <= mid - CW'(1);
        end
      end
      // best fit scan
      mrt_pkg::S_FIT_CMP: begin
        if (fit_cand) begin
          res_idx  <= idx_i[IW-1:0];
          res_base <= rdata.base;
          res_len  <= rdata.len;
          res_free <= rdata.free;
          have     <= 1'b1;
        end
        idx_i <= idx_i + CW'(1);
        if (idx_i + CW'(1) >= count && !(have || fit_cand)) begin
          res_status <= mrt_pkg::ST_NOTFOUND;
        end
      end
      // insertion sort by base
      mrt_pkg::S_SORT_KEY_RD: idx_j <= idx_i;
      mrt_pkg::S_SORT_KEY:    key   <= rdata;
      mrt_pkg::S_SORT_CMP:    if (sort_gt) idx_j <= idx_j - CW'(1);
      mrt_pkg::S_SORT_PUT:    idx_i <= idx_i + CW'(1);
      // join pass
      mrt_pkg::S_MRG_START: begin
        idx_i   <= CW'(1);
        out_idx <= '0;
      end
      mrt_pkg::S_MRG_FIRST: cur <= rdata;
      mrt_pkg::S_MRG_CMP: begin
        if (mrg_join) begin
          cur.len <= cur.len + rdata.len;
        end else begin
          cur     <= rdata;
          out_idx <= out_idx + CW'(1);
        end
        idx_i <= idx_i + CW'(1);
      end
      // split
      mrt_pkg::S_SPL_CHK: begin
        key   <= rdata;
        idx_i <= count;
        if (off_q >= rdata.len) begin
          res_status <= mrt_pkg::ST_BADSPLIT;
        end else if (count >= MAX_CNT) begin
          res_status <= mrt_pkg::ST_FULL;
        end
      end
      mrt_pkg::S_SPL_SHIFT_WR: idx_i <= idx_i - CW'(1);
      mrt_pkg::S_SPL_CUT: begin
        res_idx  <= eidx;
        res_base <= key.base;
        res_len  <= off_q;
        res_free <= key.free;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == mrt_pkg::S_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == mrt_pkg::S_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {count, res_free, res_len, res_base, res_idx, res_status};
    end
  end

endmodule
